@@ rtl/ssf_pkg.sv @@
// Shared types and constants for the substring search forward unit.
// No dependencies; used by ssf_matcher and the top level.
package ssf_pkg;

    localparam int PAT_BYTES = 16;      // pattern register capacity in bytes
    localparam int LEN_W     = 5;       // pattern_length width
    localparam int OFS_W     = 16;      // start_offset / match position width
    localparam int APB_AW    = 5;       // registers at 8-byte strides
    localparam int APB_DW    = 64;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_PAT_LO  = 2'd0;
    localparam logic [1:0] REG_PAT_HI  = 2'd1;
    localparam logic [1:0] REG_PAT_LEN = 2'd2;
    localparam logic [1:0] REG_START   = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] t_pat_bytes;

    // shift request into the byte window
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_shift;

endpackage

@@ rtl/ssf_matcher.sv @@
// Byte window of the most recent text bytes and the parallel pattern compare.
// Depends on ssf_pkg.
module ssf_matcher
    import ssf_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic             i_clk,
    input  t_shift           i_shift,
    input  t_pat_bytes       i_pattern,
    input  logic [LEN_W-1:0] i_len,      // already limited to PATTERN_MAX
    output logic             o_hit       // window after this shift ends on the pattern
);

    logic [7:0] r_win [PATTERN_MAX];
    logic [7:0] n_win [PATTERN_MAX];

    // newest byte at index 0
    always_comb begin
        n_win[0] = i_shift.data;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_win[i] = r_win[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift.en) begin
            r_win <= n_win;
        end
    end

    // window byte j pairs with pattern byte len-1-j
    always_comb begin
        o_hit = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((LEN_W'(j) < i_len) &&
                (n_win[j] != i_pattern[4'(i_len - LEN_W'(j) - LEN_W'(1))])) begin
                o_hit = 1'b0;
            end
        end
    end

endmodule

@@ rtl/substring_search_forward_unit.sv @@
// Top level of the streaming forward substring search.
// Depends on ssf_pkg and ssf_matcher.

// One text word can enter per cycle while o_in_stall is low. A word is first
// captured in an input register, then shifted into a PATTERN_MAX-byte window
// and the window is compared against the pattern in parallel, updating the
// first-match state. A word flagged last_byte loads the result register
// (found, match_position, overflow) and clears the text state, so the next
// text may start right behind it. The input side stalls only when a last word
// must load the result register while an earlier result is still held there
// by i_out_stall; all other words flow through regardless. The byte position
// counter saturates at TEXT_MAX; bytes past that point only set the overflow
// flag. Registers sit on an APB port at 8-byte strides (64-bit data); they
// must be written only while idle, which the block itself does not enforce.
module substring_search_forward_unit
    import ssf_pkg::*;
#(
    parameter int              PATTERN_MAX = 16,
    parameter longint unsigned TEXT_MAX    = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // text input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_text_byte,
    input  logic              i_last_byte,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_found,
    output logic [OFS_W-1:0]  o_match_position,
    output logic              o_overflow,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // position counter holds 0..TEXT_MAX
    localparam int POS_W = $clog2(TEXT_MAX + 1);
    // arithmetic width: room for position + 1 and for a 16-bit offset compare
    localparam int WK_W  = (POS_W + 1 > OFS_W + 1) ? POS_W + 1 : OFS_W + 1;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(TEXT_MAX);

    // ---------------- registers ----------------
    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [LEN_W-1:0] r_pattern_length;
    logic [OFS_W-1:0] r_start_offset;
    logic             w_wr;
    logic [1:0]       w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= '0;
            r_start_offset   <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_PAT_LO:  r_pattern_low    <= pwdata;
                REG_PAT_HI:  r_pattern_high   <= pwdata;
                REG_PAT_LEN: r_pattern_length <= pwdata[LEN_W-1:0];
                REG_START:   r_start_offset   <= pwdata[OFS_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_LO:  prdata = r_pattern_low;
            REG_PAT_HI:  prdata = r_pattern_high;
            REG_PAT_LEN: prdata = APB_DW'(r_pattern_length);
            REG_START:   prdata = APB_DW'(r_start_offset);
            default:     prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       w_adv;     // stage 2 consumes the held word this cycle
    logic       w_take;    // input word accepted

    // a last word needs a free (or draining) result register
    assign w_adv      = !(r_in_last && o_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_last_byte;
        end
    end

    // ---------------- search stage ----------------
    logic [POS_W-1:0] r_pos;
    logic             r_seen;
    logic [OFS_W-1:0] r_first;
    logic             r_exceeded;
    logic [POS_W-1:0] n_pos;
    logic             n_seen;
    logic [OFS_W-1:0] n_first;
    logic             n_exceeded;

    logic             w_step;     // a word is processed
    logic             w_sat;      // position already at TEXT_MAX
    logic [LEN_W-1:0] w_len;      // pattern length limited to PATTERN_MAX
    logic             w_hit;
    logic [WK_W-1:0]  w_p1;       // position + 1
    logic [WK_W-1:0]  w_len_x;
    logic [WK_W-1:0]  w_cand;     // candidate start
    logic [WK_W-1:0]  w_ofs_x;
    t_shift           w_shift;

    assign w_step  = r_in_valid && w_adv;
    assign w_sat   = (r_pos == POS_SAT);
    assign w_len   = (r_pattern_length > LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : r_pattern_length;
    assign w_p1    = WK_W'(r_pos) + WK_W'(1);
    assign w_len_x = WK_W'(w_len);
    assign w_cand  = w_p1 - w_len_x;
    assign w_ofs_x = WK_W'(r_start_offset);

    assign w_shift.en   = w_step && !w_sat;
    assign w_shift.data = r_in_byte;

    ssf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_matcher (
        .i_clk     (i_clk),
        .i_shift   (w_shift),
        .i_pattern (t_pat_bytes'({r_pattern_high, r_pattern_low})),
        .i_len     (w_len),
        .o_hit     (w_hit)
    );

    always_comb begin
        n_pos      = r_pos;
        n_seen     = r_seen;
        n_first    = r_first;
        n_exceeded = r_exceeded;
        if (w_sat) begin
            n_exceeded = 1'b1;
        end else begin
            if (!r_seen) begin
                if (w_len == '0) begin
                    // empty pattern hits exactly at the start offset
                    if (WK_W'(r_pos) == w_ofs_x) begin
                        n_seen  = 1'b1;
                        n_first = r_start_offset;
                    end
                end else if (w_p1 >= w_len_x) begin
                    if (w_hit && (w_cand >= w_ofs_x) &&
                        (w_cand <= WK_W'({OFS_W{1'b1}}))) begin
                        n_seen  = 1'b1;
                        n_first = w_cand[OFS_W-1:0];
                    end
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_seen     <= 1'b0;
            r_first    <= '0;
            r_exceeded <= 1'b0;
        end else if (w_step) begin
            if (r_in_last) begin
                r_pos      <= '0;
                r_seen     <= 1'b0;
                r_first    <= '0;
                r_exceeded <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_seen     <= n_seen;
                r_first    <= n_first;
                r_exceeded <= n_exceeded;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_step && r_in_last) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_in_last) begin
            o_found          <= n_seen;
            o_match_position <= n_seen ? n_first : '0;
            o_overflow       <= n_exceeded;
        end
    end

endmodule

@@ rtl/ssf_checker.sv @@
// Port-level checks for substring_search_forward_unit, bound to the top level.
// Depends on ssf_pkg.
module ssf_checker
    import ssf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             i_last_byte,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic             o_found,
    input logic [OFS_W-1:0] o_match_position
);

    // a fresh result follows a taken last word, by way of the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte, 2))
        else $error("result without a preceding last word");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_position == '0))
        else $error("match position nonzero while not found");

    // input backs up only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with result side free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_found) &&
                                          $stable(o_match_position)))
        else $error("stalled result changed");

endmodule

bind substring_search_forward_unit ssf_checker u_ssf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_last_byte      (i_last_byte),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_found          (o_found),
    .o_match_position (o_match_position)
);
